FILE: design/plp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and register indexes for the point/line projection core.
// No dependencies.
package plp_pkg;

   localparam int COORD_W      = 16;  // input coordinate / register width
   localparam int DIFF_W       = 17;  // endpoint and point differences
   localparam int SQ_W         = 34;  // 17x17 signed products
   localparam int DOT_W        = 35;  // dot product a.b
   localparam int NRM_W        = 34;  // squared length |a|^2, unsigned
   localparam int NUM_X_W      = 52;  // widest first-rank product (17 x 35)
   localparam int SUM_W        = 53;  // p1*n + a*d
   localparam int NUM_W        = 55;  // 2*(p1*n + a*d) - p*n
   localparam int MAG_W        = 55;  // magnitude of the numerator
   localparam int DEN_W        = 35;  // divisor 2*n
   localparam int OUT_W        = 35;  // Q.F result coordinate
   localparam int CSR_IDX_W    = 2;
   localparam int FRACTION_BITS_DEF = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_START_X = 2'd0,
      CSR_LINE_START_Y = 2'd1,
      CSR_LINE_END_X   = 2'd2,
      CSR_LINE_END_Y   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_PROJECT = 1'b0,
      CMD_REFLECT = 1'b1
   } cmd_type;

endpackage

FILE: design/point_line_projection_core.sv
`timescale 1ns / 1ps
// Top level: projects or reflects streamed points against a configured 2-D line.
// Depends on plp_pkg.
//
//  channel  | direction | accept when           | contents
//  ---------+-----------+-----------------------+------------------------------------
//  req_*    | in        | req_tvalid&req_tready | tdata {point_y, point_x}, tuser cmd
//  rsp_*    | out       | rsp_tvalid&rsp_tready | tdata {result_y, result_x}, tuser degenerate
//  csr_*    | in        | csr_wr_en             | index selects a line endpoint coordinate
//
// One request enters per cycle while rsp is not stalled. The pipeline has seven arithmetic
// stages, one restoring-division step per stage for FRACTION_BITS + 22 quotient bits,
// and the output register. The division chain sets the depth.
// Reset is synchronous and clears the valid bits and the line registers
// (start (0,0), end (1,0)). A stall on rsp freezes the whole pipeline at once, so
// nothing is dropped or repeated; bubbles keep flowing while rsp_tvalid is low.
module point_line_projection_core #(
   parameter int FRACTION_BITS = plp_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = point_x [15:0], point_y [31:16]; tuser = cmd
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*plp_pkg::COORD_W-1:0]     req_tdata,
   input  logic                              req_tuser,
   // response: tdata = result_x [34:0], result_y [69:35], zero fill [71:70]
   //           tuser = degenerate
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [71:0]                       rsp_tdata,
   output logic                              rsp_tuser,
   // register writes
   input  logic                              csr_wr_en,
   input  logic [plp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [plp_pkg::COORD_W-1:0]       csr_wdata
);
   import plp_pkg::*;

   localparam int DW = MAG_W + FRACTION_BITS + 2;  // dividend width
   localparam int QW = DW - DEN_W;                 // quotient bits, one per stage
   localparam int SW = ((QW > OUT_W) ? QW : OUT_W) + 1;
   localparam logic [SW-1:0] POS_LIM = SW'((64'd1 << (OUT_W - 1)) - 64'd1);
   localparam logic [SW-1:0] NEG_LIM = SW'(64'd1 << (OUT_W - 1));

   // ---------------- line registers ----------------
   logic signed [COORD_W-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= COORD_W'(1);
         end_y_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LINE_START_X: start_x_ff <= csr_wdata;
            CSR_LINE_START_Y: start_y_ff <= csr_wdata;
            CSR_LINE_END_X:   end_x_ff   <= csr_wdata;
            CSR_LINE_END_Y:   end_y_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the whole pipe unless a finished response is held back.
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: differences ----------------
   logic                       v1_ff;
   logic                       cmd1_ff;
   logic signed [COORD_W-1:0]  px1_ff, py1_ff, sx1_ff, sy1_ff;
   logic signed [DIFF_W-1:0]   ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic signed [COORD_W-1:0]  in_px, in_py;

   assign in_px = req_tdata[COORD_W-1:0];
   assign in_py = req_tdata[2*COORD_W-1:COORD_W];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd1_ff <= req_tuser;
         px1_ff  <= in_px;
         py1_ff  <= in_py;
         sx1_ff  <= start_x_ff;
         sy1_ff  <= start_y_ff;
         ax1_ff  <= DIFF_W'(end_x_ff) - DIFF_W'(start_x_ff);
         ay1_ff  <= DIFF_W'(end_y_ff) - DIFF_W'(start_y_ff);
         bx1_ff  <= DIFF_W'(in_px) - DIFF_W'(start_x_ff);
         by1_ff  <= DIFF_W'(in_py) - DIFF_W'(start_y_ff);
      end
   end

   // ---------------- stage 2: squares and cross terms ----------------
   logic                       v2_ff, cmd2_ff;
   logic signed [COORD_W-1:0]  px2_ff, py2_ff, sx2_ff, sy2_ff;
   logic signed [DIFF_W-1:0]   ax2_ff, ay2_ff;
   logic signed [SQ_W-1:0]     abx2_ff, aby2_ff, aax2_ff, aay2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd2_ff <= cmd1_ff;
         px2_ff  <= px1_ff;
         py2_ff  <= py1_ff;
         sx2_ff  <= sx1_ff;
         sy2_ff  <= sy1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         abx2_ff <= SQ_W'(ax1_ff) * SQ_W'(bx1_ff);
         aby2_ff <= SQ_W'(ay1_ff) * SQ_W'(by1_ff);
         aax2_ff <= SQ_W'(ax1_ff) * SQ_W'(ax1_ff);
         aay2_ff <= SQ_W'(ay1_ff) * SQ_W'(ay1_ff);
      end
   end

   // ---------------- stage 3: dot product and squared length ----------------
   logic                       v3_ff, cmd3_ff;
   logic signed [COORD_W-1:0]  px3_ff, py3_ff, sx3_ff, sy3_ff;
   logic signed [DIFF_W-1:0]   ax3_ff, ay3_ff;
   logic signed [DOT_W-1:0]    dot3_ff;
   logic [NRM_W-1:0]           nrm3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd3_ff <= cmd2_ff;
         px3_ff  <= px2_ff;
         py3_ff  <= py2_ff;
         sx3_ff  <= sx2_ff;
         sy3_ff  <= sy2_ff;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         dot3_ff <= DOT_W'(abx2_ff) + DOT_W'(aby2_ff);
         // both squares are non-negative, their sum fits unsigned
         nrm3_ff <= NRM_W'(aax2_ff) + NRM_W'(aay2_ff);
      end
   end

   // ---------------- stage 4: scale by n and d ----------------
   logic                       v4_ff, cmd4_ff, deg4_ff;
   logic signed [COORD_W-1:0]  sx4_ff, sy4_ff;
   logic [NRM_W-1:0]           nrm4_ff;
   logic signed [NUM_X_W-1:0]  snx4_ff, sny4_ff, adx4_ff, ady4_ff, pnx4_ff, pny4_ff;
   logic signed [NRM_W:0]      nrm3_s;

   assign nrm3_s = $signed({1'b0, nrm3_ff});

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd4_ff <= cmd3_ff;
         deg4_ff <= (nrm3_ff == '0);
         sx4_ff  <= sx3_ff;
         sy4_ff  <= sy3_ff;
         nrm4_ff <= nrm3_ff;
         snx4_ff <= NUM_X_W'(sx3_ff) * NUM_X_W'(nrm3_s);
         sny4_ff <= NUM_X_W'(sy3_ff) * NUM_X_W'(nrm3_s);
         adx4_ff <= NUM_X_W'(ax3_ff) * NUM_X_W'(dot3_ff);
         ady4_ff <= NUM_X_W'(ay3_ff) * NUM_X_W'(dot3_ff);
         pnx4_ff <= NUM_X_W'(px3_ff) * NUM_X_W'(nrm3_s);
         pny4_ff <= NUM_X_W'(py3_ff) * NUM_X_W'(nrm3_s);
      end
   end

   // ---------------- stage 5: projection numerators ----------------
   logic                       v5_ff, cmd5_ff, deg5_ff;
   logic signed [COORD_W-1:0]  sx5_ff, sy5_ff;
   logic [NRM_W-1:0]           nrm5_ff;
   logic signed [SUM_W-1:0]    ux5_ff, uy5_ff;
   logic signed [NUM_X_W-1:0]  pnx5_ff, pny5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmd5_ff <= cmd4_ff;
         deg5_ff <= deg4_ff;
         sx5_ff  <= sx4_ff;
         sy5_ff  <= sy4_ff;
         nrm5_ff <= nrm4_ff;
         ux5_ff  <= SUM_W'(snx4_ff) + SUM_W'(adx4_ff);
         uy5_ff  <= SUM_W'(sny4_ff) + SUM_W'(ady4_ff);
         pnx5_ff <= pnx4_ff;
         pny5_ff <= pny4_ff;
      end
   end

   // ---------------- stage 6: reflection, degenerate override ----------------
   logic                       v6_ff, deg6_ff;
   logic signed [NUM_W-1:0]    numx6_ff, numy6_ff;
   logic [NRM_W-1:0]           nrm6_ff;
   logic signed [NUM_W-1:0]    numx_in, numy_in;
   logic signed [NUM_W-1:0]    refx, refy;

   assign refx = (NUM_W'(ux5_ff) <<< 1) - NUM_W'(pnx5_ff);
   assign refy = (NUM_W'(uy5_ff) <<< 1) - NUM_W'(pny5_ff);

   always_comb begin
      if (deg5_ff) begin
         // coinciding endpoints: return p1, divide by one
         numx_in = NUM_W'(sx5_ff);
         numy_in = NUM_W'(sy5_ff);
      end else if (cmd_type'(cmd5_ff) == CMD_REFLECT) begin
         numx_in = refx;
         numy_in = refy;
      end else begin
         numx_in = NUM_W'(ux5_ff);
         numy_in = NUM_W'(uy5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         deg6_ff  <= deg5_ff;
         numx6_ff <= numx_in;
         numy6_ff <= numy_in;
         nrm6_ff  <= deg5_ff ? NRM_W'(1) : nrm5_ff;
      end
   end

   // ---------------- stage 7 and divider ----------------
   // Rounded quotient = floor((2*|num|*2^F + n) / (2n)). Entry 0 holds the
   // prepared dividend; entry k+1 holds the state after quotient bit k.
   logic [QW:0]         dv_ff;
   logic [QW:0]         ddeg_ff;
   logic [QW:0]         negx_ff, negy_ff;
   logic [DEN_W-1:0]    den_ff  [QW+1];
   logic [DEN_W-1:0]    remx_ff [QW+1];
   logic [DEN_W-1:0]    remy_ff [QW+1];
   logic [QW-1:0]       lowx_ff [QW+1];
   logic [QW-1:0]       lowy_ff [QW+1];

   logic [MAG_W-1:0]    magx, magy;
   logic [DW-1:0]       dx, dy;

   assign magx = numx6_ff[NUM_W-1] ? MAG_W'(-numx6_ff) : MAG_W'(numx6_ff);
   assign magy = numy6_ff[NUM_W-1] ? MAG_W'(-numy6_ff) : MAG_W'(numy6_ff);
   assign dx   = (DW'(magx) << (FRACTION_BITS + 1)) + DW'(nrm6_ff);
   assign dy   = (DW'(magy) << (FRACTION_BITS + 1)) + DW'(nrm6_ff);

   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else if (adv) dv_ff <= {dv_ff[QW-1:0], v6_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ddeg_ff[0] <= deg6_ff;
         negx_ff[0] <= numx6_ff[NUM_W-1];
         negy_ff[0] <= numy6_ff[NUM_W-1];
         den_ff[0]  <= {nrm6_ff, 1'b0};
         remx_ff[0] <= dx[DW-1:QW];
         remy_ff[0] <= dy[DW-1:QW];
         lowx_ff[0] <= dx[QW-1:0];
         lowy_ff[0] <= dy[QW-1:0];
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DEN_W:0] trial_x, trial_y;
      logic           ge_x, ge_y;

      assign trial_x = {remx_ff[k], lowx_ff[k][QW-1]};
      assign trial_y = {remy_ff[k], lowy_ff[k][QW-1]};
      assign ge_x    = trial_x >= {1'b0, den_ff[k]};
      assign ge_y    = trial_y >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         if (adv) begin
            ddeg_ff[k+1] <= ddeg_ff[k];
            negx_ff[k+1] <= negx_ff[k];
            negy_ff[k+1] <= negy_ff[k];
            den_ff[k+1]  <= den_ff[k];
            remx_ff[k+1] <= ge_x ? DEN_W'(trial_x - {1'b0, den_ff[k]})
                                 : trial_x[DEN_W-1:0];
            remy_ff[k+1] <= ge_y ? DEN_W'(trial_y - {1'b0, den_ff[k]})
                                 : trial_y[DEN_W-1:0];
            // shift the dividend out and the quotient bit in
            lowx_ff[k+1] <= {lowx_ff[k][QW-2:0], ge_x};
            lowy_ff[k+1] <= {lowy_ff[k][QW-2:0], ge_y};
         end
      end
   end

   // ---------------- output stage: saturate and restore the sign ----------------
   logic [SW-1:0]      qx, qy, satx, saty;
   logic [OUT_W-1:0]   resx_in, resy_in;
   logic [OUT_W-1:0]   resx_ff, resy_ff;
   logic               deg_out_ff;

   assign qx = SW'(lowx_ff[QW]);
   assign qy = SW'(lowy_ff[QW]);

   always_comb begin
      if (negx_ff[QW]) satx = (qx > NEG_LIM) ? NEG_LIM : qx;
      else             satx = (qx > POS_LIM) ? POS_LIM : qx;
      if (negy_ff[QW]) saty = (qy > NEG_LIM) ? NEG_LIM : qy;
      else             saty = (qy > POS_LIM) ? POS_LIM : qy;
      resx_in = negx_ff[QW] ? OUT_W'(-satx) : OUT_W'(satx);
      resy_in = negy_ff[QW] ? OUT_W'(-saty) : OUT_W'(saty);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         resx_ff    <= resx_in;
         resy_ff    <= resy_in;
         deg_out_ff <= ddeg_ff[QW];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, resy_ff, resx_ff};
   assign rsp_tuser  = deg_out_ff;

   // ---------------- assertions ----------------
   // A held response freezes every valid bit in the pipe.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable({v1_ff, v2_ff, v3_ff, v4_ff, v5_ff,
                                                v6_ff, dv_ff}))
      else $error("pipeline moved during a response stall");

   // The partial remainder leaving the divider stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      dv_ff[QW] |-> (remx_ff[QW] < den_ff[QW] && remy_ff[QW] < den_ff[QW]))
      else $error("divider remainder out of range");

   // A degenerate line enters the divider with divisor two.
   a_deg_den: assert property (@(posedge clock) disable iff (reset)
      (dv_ff[0] && ddeg_ff[0]) |-> (den_ff[0] == DEN_W'(2)))
      else $error("degenerate request with wrong divisor");

   // The top dividend slice never reaches the divisor, so the quotient fits.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      dv_ff[0] |-> (remx_ff[0] < den_ff[0] && remy_ff[0] < den_ff[0]))
      else $error("quotient wider than the divider");

endmodule

FILE: test/point_line_projection_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for point_line_projection_core: streams points through the
// core under several line settings and handshake patterns, checking each response.
// Depends on plp_pkg and the core.
module point_line_projection_core_tb;
   import plp_pkg::*;

   localparam int LATENCY = FRACTION_BITS_DEF + 30;

   typedef struct packed {
      logic [OUT_W-1:0] rx;
      logic [OUT_W-1:0] ry;
      logic             degen;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]   csr_wdata = '0;

   // line endpoints as the bench believes them
   logic signed [15:0] start_x, start_y, end_x, end_y;
   answer_type answers_due[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;

   point_line_projection_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // round(num * 2^16 / den), ties away from zero, saturated to 35 bits
   function automatic logic [OUT_W-1:0] round_fixed(input longint signed num,
                                                    input longint unsigned den);
      logic neg;
      longint unsigned mag, whole, rem, frac_num, frac_q, frac_r, total, lim;
      neg = num < 0;
      mag = neg ? -num : num;
      whole = mag / den;
      rem = mag % den;
      frac_num = rem << FRACTION_BITS_DEF;
      frac_q = frac_num / den;
      frac_r = frac_num % den;
      lim = 64'd1 << (OUT_W - 1);
      if (frac_r >= den - frac_r) frac_q++;
      total = (whole << FRACTION_BITS_DEF) + frac_q;
      if (neg) begin
         if (total > lim) total = lim;
         return OUT_W'(-total);
      end
      if (total > lim - 1) total = lim - 1;
      return OUT_W'(total);
   endfunction

   function automatic answer_type project_point(input logic reflect,
                                                input logic signed [15:0] px,
                                                input logic signed [15:0] py);
      longint signed ax, ay, dot, ux, uy;
      longint unsigned nrm;
      answer_type a;
      ax = longint'(end_x) - start_x;
      ay = longint'(end_y) - start_y;
      dot = ax * (px - longint'(start_x)) + ay * (py - longint'(start_y));
      nrm = ax * ax + ay * ay;
      if (nrm == 0) begin
         a.rx = round_fixed(start_x, 1);
         a.ry = round_fixed(start_y, 1);
         a.degen = 1'b1;
         return a;
      end
      ux = longint'(start_x) * longint'(nrm) + ax * dot;
      uy = longint'(start_y) * longint'(nrm) + ay * dot;
      if (reflect) begin
         ux = 2 * ux - longint'(px) * longint'(nrm);
         uy = 2 * uy - longint'(py) * longint'(nrm);
      end
      a.rx = round_fixed(ux, nrm);
      a.ry = round_fixed(uy, nrm);
      a.degen = 1'b0;
      return a;
   endfunction

   // offer one request, record its answer once the core takes it;
   // tvalid stays high on return, so a caller that stops sending drops it
   task automatic send_point(input cmd_type cmd, input logic [15:0] px,
                             input logic [15:0] py);
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answers_due.push_back(project_point(cmd, px, py));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_line(input logic [15:0] sx, input logic [15:0] sy,
                             input logic [15:0] ex, input logic [15:0] ey);
      csr_index_type idx;
      logic [15:0] vals[4];
      vals = '{sx, sy, ex, ey};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      start_x = sx; start_y = sy; end_x = ex; end_y = ey;
      @(posedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_point(cmd_type'($urandom_range(1, 0)), 16'($urandom), 16'($urandom));
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // checker: compare each accepted response with the oldest answer due
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = answers_due.pop_front();
            if (rsp_tdata[34:0] !== want.rx) begin
               $display("%0t: result_x expected %h actual %h", $time, want.rx,
                        rsp_tdata[34:0]);
               errors++;
            end
            if (rsp_tdata[69:35] !== want.ry) begin
               $display("%0t: result_y expected %h actual %h", $time, want.ry,
                        rsp_tdata[69:35]);
               errors++;
            end
            if (rsp_tdata[71:70] !== 2'b00) begin
               $display("%0t: fill expected 0 actual %b", $time, rsp_tdata[71:70]);
               errors++;
            end
            if (rsp_tuser !== want.degen) begin
               $display("%0t: degenerate expected %b actual %b", $time, want.degen,
                        rsp_tuser);
               errors++;
            end
         end
      end
   end

   task automatic test_reset_line();
      // reset line runs along the x axis
      start_x = 0; start_y = 0; end_x = 1; end_y = 0;
      send_point(CMD_PROJECT, 16'd5, 16'd7);
      send_point(CMD_REFLECT, 16'd5, 16'd7);
      send_point(CMD_PROJECT, 16'h8000, 16'h7fff);
      send_point(CMD_REFLECT, 16'h7fff, 16'h8000);
   endtask

   task automatic test_directed();
      logic [15:0] ext[4];
      ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      write_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
      for (int i = 0; i < 4; i++) begin
         send_point(CMD_PROJECT, ext[i], ext[3-i]);
         send_point(CMD_REFLECT, ext[i], ext[i]);
      end
      write_line(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_point(CMD_REFLECT, 16'h8000, 16'h8000);
      send_point(CMD_PROJECT, 16'h7fff, 16'h7fff);
      // coinciding endpoints: degenerate for both commands
      write_line(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_point(CMD_PROJECT, 16'd3, 16'd4);
      send_point(CMD_REFLECT, 16'h7fff, 16'h8000);
      // rounding of non-integer results: line through (0,0),(2,1)
      write_line(16'd0, 16'd0, 16'd2, 16'd1);
      send_point(CMD_PROJECT, 16'd1, 16'd0);
      send_point(CMD_REFLECT, 16'hffff, 16'd0);
      send_point(CMD_PROJECT, 16'd3, 16'd3);
   endtask

   task automatic test_random_phases();
      int idle[4], stall[4];
      idle = '{0, 47, 0, 34};
      stall = '{0, 0, 47, 34};
      for (int ph = 0; ph < 4; ph++) begin
         // new random line each phase; sometimes degenerate, sometimes short
         case ($urandom_range(2, 0))
            0: write_line(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            1: write_line(16'($urandom_range(7, 0)), 16'($urandom_range(7, 0)),
                          16'($urandom_range(7, 0)), 16'($urandom_range(7, 0)));
            default: write_line(16'd100, 16'hff00, 16'd100, 16'hff00);
         endcase
         send_idle_pct = idle[ph];
         recv_stall_pct = stall[ph];
         send_random(420);
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      write_line(16'd12, 16'hfff0, 16'h1234, 16'h8765);
      hold_off_cycles = 3 * LATENCY;
      send_random(150);
      // pause until everything has come back, then go on
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      send_random(20);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_line();
      test_directed();
      test_random_phases();
      test_backpressure();
      wait_drained();
      if (errors == 0) begin
         $display("PASS point_line_projection_core");
      end else begin
         $display("FAIL point_line_projection_core");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL point_line_projection_core");
      $finish;
   end
endmodule

FILE: files.f
design/plp_pkg.sv
design/point_line_projection_core.sv
test/point_line_projection_core_tb.sv
